/* hdl/luhn_card_number_check_unit_macros.svh */
// ---------------------------------------------------------------------------
// Luhn card number check: assertion macros
// Shared concurrent assertion forms for the Luhn check pipeline.
// ---------------------------------------------------------------------------
`ifndef LUHN_CARD_NUMBER_CHECK_UNIT_MACROS_SVH
`define LUHN_CARD_NUMBER_CHECK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCNC_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("lcnc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCNC_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("lcnc assertion failed");

`endif

/* hdl/lcnc_pkg.sv */
// ---------------------------------------------------------------------------
// Luhn card number check: package
// Widths, brand codes and digit helpers for the Luhn check pipeline.
// ---------------------------------------------------------------------------
package lcnc_pkg;

	localparam int CARD_W      = 54;
	localparam int IN_TDATA_W  = 56;
	localparam int SUM_W       = 8;
	localparam int BRAND_W     = 2;
	localparam int OUT_TDATA_W = 16;

	localparam int MAX_DIGITS = 16;
	localparam int DIGIT_W    = 4;
	localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
	localparam int LEN_W      = 5;

	// double-dabble: input bits consumed per pipeline stage
	localparam int DD_BITS   = 8;
	localparam int DD_STAGES = (CARD_W + DD_BITS - 1) / DD_BITS;
	localparam int DD_W      = DD_STAGES * DD_BITS;

	// 10^MAX_DIGITS; any 54-bit word is below twice this value
	localparam logic [CARD_W-1:0] CARD_LIMIT = 54'd10000000000000000;

	typedef enum logic [BRAND_W-1:0] {
		BRAND_NONE = 2'd0,
		BRAND_VISA = 2'd1,
		BRAND_AMEX = 2'd2,
		BRAND_MC   = 2'd3
	} brand_t;

	// digit sum of twice a decimal digit
	function automatic logic [DIGIT_W-1:0] luhn_dbl(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W-1:0] r;
		case (d)
			4'd0:    r = 4'd0;
			4'd1:    r = 4'd2;
			4'd2:    r = 4'd4;
			4'd3:    r = 4'd6;
			4'd4:    r = 4'd8;
			4'd5:    r = 4'd1;
			4'd6:    r = 4'd3;
			4'd7:    r = 4'd5;
			4'd8:    r = 4'd7;
			4'd9:    r = 4'd9;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// one block of double-dabble steps: add 3 to each digit at or above 5, shift in
	function automatic logic [BCD_W+DD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd_in,
		input logic [DD_W-1:0] bin_in);
		logic [BCD_W-1:0] bcd;
		logic [DD_W-1:0]  bin;
		bcd = bcd_in;
		bin = bin_in;
		for (int i = 0; i < DD_BITS; i++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5)
					bcd[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
			end
			bcd = {bcd[BCD_W-2:0], bin[DD_W-1]};
			bin = {bin[DD_W-2:0], 1'b0};
		end
		return {bcd, bin};
	endfunction

	// every nibble is a decimal digit
	function automatic logic bcd_valid(input logic [BCD_W-1:0] bcd);
		logic ok;
		ok = 1'b1;
		for (int d = 0; d < MAX_DIGITS; d++) begin
			if (bcd[d*DIGIT_W +: DIGIT_W] > 4'd9)
				ok = 1'b0;
		end
		return ok;
	endfunction

endpackage

/* hdl/luhn_card_number_check_unit.sv */
// ---------------------------------------------------------------------------
// Luhn card number check unit
// Streaming Luhn mod-10 check with card brand decode, fully pipelined.
// ---------------------------------------------------------------------------
// One card number word enters per clock and one result word leaves per clock
// at full rate while the result side keeps m_axis_tready high; the length of
// the pipeline is set by the binary-to-decimal conversion:
// seven double-dabble stages of eight bits each over the 54-bit number, after
// one stage that folds the number below 10^16 and before a digit-sum stage and
// the output register that decides pass/fail and brand. Each stage holds its
// word while the next one is full and stalled, so bubbles collapse and
// back-pressure on the result side reaches the input only once the whole
// pipeline is full. The result carries the Luhn sum (0..144), the pass flag
// (sum divisible by ten) and a brand code: VISA for 13 or 16 digits starting
// with 4, AMEX for 15 digits starting with 34 or 37, MASTERCARD for 16 digits
// starting with 51..55, and none otherwise or whenever the check fails.
// Numbers of 10^16 or more keep only their low sixteen digits.
// ---------------------------------------------------------------------------
`include "luhn_card_number_check_unit_macros.svh"

module luhn_card_number_check_unit
	import lcnc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [53:0] card_number
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [7:0] checksum_sum, [8] checksum_ok,
	                                               // [10:9] brand
);

	// stage map: 0 fold, 1..DD_STAGES convert, SUM_STG digit sum, OUT_STG result
	localparam int SUM_STG = DD_STAGES + 1;
	localparam int OUT_STG = DD_STAGES + 2;
	localparam int NSTG    = DD_STAGES + 3;

	logic vld_s [NSTG];
	logic rdy   [NSTG];

	// ready chain: a stage takes a word when empty or when it hands its word on
	always_comb begin
		rdy[OUT_STG] = !vld_s[OUT_STG] || m_axis_tready;
		for (int k = OUT_STG - 1; k >= 0; k--)
			rdy[k] = !vld_s[k] || rdy[k+1];
	end

	assign s_axis_tready = rdy[0];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSTG; k++)
				vld_s[k] <= 1'b0;
		end else begin
			if (rdy[0])
				vld_s[0] <= s_axis_tvalid;
			for (int k = 1; k < NSTG; k++) begin
				if (rdy[k])
					vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: fold the number below 10^16 (one compare and subtract)
	// -----------------------------------------------------------------------
	logic [CARD_W-1:0] card_in;
	logic [CARD_W-1:0] card_s1;

	assign card_in = s_axis_tdata[CARD_W-1:0];

	always_ff @(posedge clk) begin
		if (rdy[0] && s_axis_tvalid)
			card_s1 <= (card_in >= CARD_LIMIT) ? (card_in - CARD_LIMIT) : card_in;
	end

	// -----------------------------------------------------------------------
	// Stages 2..DD_STAGES+1: double-dabble conversion, MSB first
	// -----------------------------------------------------------------------
	logic [BCD_W-1:0] dd_bcd_s [1:DD_STAGES];
	logic [DD_W-1:0]  dd_bin_s [1:DD_STAGES-1];

	genvar j;
	generate
		for (j = 1; j <= DD_STAGES; j++) begin : g_dd
			logic [BCD_W-1:0]      bcd_in;
			logic [DD_W-1:0]       bin_in;
			logic [BCD_W+DD_W-1:0] step;

			if (j == 1) begin : g_first
				assign bcd_in = '0;
				assign bin_in = {{(DD_W-CARD_W){1'b0}}, card_s1};
			end else begin : g_next
				assign bcd_in = dd_bcd_s[j-1];
				assign bin_in = dd_bin_s[j-1];
			end

			assign step = dd_step(bcd_in, bin_in);

			always_ff @(posedge clk) begin
				if (rdy[j] && vld_s[j-1])
					dd_bcd_s[j] <= step[BCD_W+DD_W-1:DD_W];
			end

			// the last stage has no input bits left to pass on
			if (j < DD_STAGES) begin : g_bin
				always_ff @(posedge clk) begin
					if (rdy[j] && vld_s[j-1])
						dd_bin_s[j] <= step[DD_W-1:0];
				end
			end
		end
	endgenerate

	// -----------------------------------------------------------------------
	// Digit-sum stage: weighted Luhn sum, significant length, leading digits
	// -----------------------------------------------------------------------
	logic [BCD_W-1:0]   digits;
	logic [SUM_W-1:0]   sum_c;
	logic [LEN_W-1:0]   len_c;
	logic [DIGIT_W-1:0] lead_c;
	logic [DIGIT_W-1:0] second_c;
	logic [DIGIT_W-1:0] prev_c;
	logic [DIGIT_W-1:0] dg;
	logic [DIGIT_W-1:0] wdig   [MAX_DIGITS];
	logic [SUM_W-1:0]   sum_l1 [MAX_DIGITS/2];
	logic [SUM_W-1:0]   sum_l2 [MAX_DIGITS/4];
	logic [SUM_W-1:0]   sum_l3 [MAX_DIGITS/8];

	logic [SUM_W-1:0]   luhn_sum_s9;
	logic [LEN_W-1:0]   len_s9;
	logic [DIGIT_W-1:0] lead_s9;
	logic [DIGIT_W-1:0] second_s9;

	assign digits = dd_bcd_s[DD_STAGES];

	always_comb begin
		len_c    = '0;
		lead_c   = '0;
		second_c = '0;
		prev_c   = '0;
		for (int k = 0; k < MAX_DIGITS; k++) begin
			dg = digits[k*DIGIT_W +: DIGIT_W];
			// odd positions from the right add as is, even positions doubled
			wdig[k] = ((k % 2) == 0) ? dg : luhn_dbl(dg);
			// track the highest nonzero digit and the one below it
			if (dg != '0) begin
				len_c    = LEN_W'(k + 1);
				lead_c   = dg;
				second_c = prev_c;
			end
			prev_c = dg;
		end
		// add the weighted digits as a balanced tree
		for (int i = 0; i < MAX_DIGITS/2; i++)
			sum_l1[i] = SUM_W'(wdig[2*i]) + SUM_W'(wdig[2*i+1]);
		for (int i = 0; i < MAX_DIGITS/4; i++)
			sum_l2[i] = sum_l1[2*i] + sum_l1[2*i+1];
		for (int i = 0; i < MAX_DIGITS/8; i++)
			sum_l3[i] = sum_l2[2*i] + sum_l2[2*i+1];
		sum_c = sum_l3[0] + sum_l3[1];
	end

	always_ff @(posedge clk) begin
		if (rdy[SUM_STG] && vld_s[SUM_STG-1]) begin
			luhn_sum_s9 <= sum_c;
			len_s9      <= len_c;
			lead_s9     <= lead_c;
			second_s9   <= second_c;
		end
	end

	// -----------------------------------------------------------------------
	// Output stage: pass flag and brand decode into the result register
	// -----------------------------------------------------------------------
	logic   ok_c;
	brand_t brand_c;

	logic [SUM_W-1:0] checksum_sum_s10;
	logic             checksum_ok_s10;
	brand_t           brand_s10;

	always_comb begin
		ok_c = luhn_sum_s9 inside {8'd0, 8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70,
			8'd80, 8'd90, 8'd100, 8'd110, 8'd120, 8'd130, 8'd140};
		brand_c = BRAND_NONE;
		if (ok_c) begin
			if ((len_s9 == 5'd13 || len_s9 == 5'd16) && lead_s9 == 4'd4)
				brand_c = BRAND_VISA;
			else if (len_s9 == 5'd15 && lead_s9 == 4'd3 &&
				(second_s9 == 4'd4 || second_s9 == 4'd7))
				brand_c = BRAND_AMEX;
			else if (len_s9 == 5'd16 && lead_s9 == 4'd5 &&
				second_s9 inside {[4'd1:4'd5]})
				brand_c = BRAND_MC;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[OUT_STG] && vld_s[SUM_STG]) begin
			checksum_sum_s10 <= luhn_sum_s9;
			checksum_ok_s10  <= ok_c;
			brand_s10        <= brand_c;
		end
	end

	assign m_axis_tvalid = vld_s[OUT_STG];
	assign m_axis_tdata  = {{(OUT_TDATA_W-SUM_W-1-BRAND_W){1'b0}}, brand_s10,
		checksum_ok_s10, checksum_sum_s10};

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	`LCNC_ASSERT_IMP(a_fold_range, clk, arst_n, vld_s[0], card_s1 < CARD_LIMIT)
	`LCNC_ASSERT_IMP(a_bcd_digits, clk, arst_n, vld_s[DD_STAGES], bcd_valid(digits))
	`LCNC_ASSERT_NXT(a_sum_hold, clk, arst_n, vld_s[SUM_STG] && !rdy[SUM_STG], vld_s[SUM_STG] && $stable(luhn_sum_s9))
	`LCNC_ASSERT_IMP(a_brand_needs_pass, clk, arst_n, vld_s[OUT_STG] && brand_s10 != BRAND_NONE, checksum_ok_s10)

endmodule
